>>> rtl/core/ldsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ldsr_pkg;

  // Request kinds carried on the input channel's tuser.
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_REFRESH = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BRIGHTNESS  = 1'b0;
  localparam logic CFG_DIGIT_COUNT = 1'b1;

  // Command bytes of the three frames.
  localparam logic [7:0] CMD_DATA_SET  = 8'h40;
  localparam logic [7:0] CMD_ADDR_SET  = 8'hC0;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h88;
  localparam logic [2:0] BRIGHT_MASK   = 3'h7;

  localparam logic [3:0] DEFAULT_COUNT  = 4'd4;
  localparam logic [2:0] DEFAULT_BRIGHT = 3'd7;
  localparam logic [3:0] GROUPED_COUNT  = 4'd6;
  localparam logic [2:0] LAST_BIT       = 3'd7;
  localparam logic [1:0] FRAME_DATA     = 2'd1;
  localparam logic [1:0] FRAME_DISPLAY  = 2'd2;

  // Store order of the digits when six digits are sent, one nibble per position
  // with the first position in the lowest nibble.
  localparam logic [23:0] SIX_ORDER = {4'd3, 4'd4, 4'd5, 4'd0, 4'd1, 4'd2};

  typedef enum logic [14:0] {
    PH_IDLE = 15'h0001,
    PH_ST0  = 15'h0002,
    PH_ST1  = 15'h0004,
    PH_ST2  = 15'h0008,
    PH_ST3  = 15'h0010,
    PH_BIT0 = 15'h0020,
    PH_BIT1 = 15'h0040,
    PH_BIT2 = 15'h0080,
    PH_ACK0 = 15'h0100,
    PH_ACK1 = 15'h0200,
    PH_ACK2 = 15'h0400,
    PH_SP0  = 15'h0800,
    PH_SP1  = 15'h1000,
    PH_SP2  = 15'h2000,
    PH_SP3  = 15'h4000
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/core/led_display_serial_refresh_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted request's result is registered; one request per cycle is taken
// unless out_tready stalls the output. The pin sequencer advances one step per tick.
// The rate is set by the single output register, which the input side may refill
// in the cycle its result is taken. Reset (rst_n low, synchronous) clears the digit
// store, idles the sequencer with both lines released high and restores defaults.
module led_display_serial_refresh_top #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] digit_index, [10:3] segments, [11] dio_sample, [15:12] zero
  input  wire logic [15:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] clk_level, [1] dio_release, [2] busy_res, [3] ack_ok, [4] rejected,
  // [5] done_res, [7:6] zero
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import ldsr_pkg::*;

  localparam int         IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [4:0] MAX_D = 5'(MAX_DIGITS);

  logic [7:0]  store_r [MAX_DIGITS];
  logic        store_we;
  logic [3:0]  store_wa;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  frame_r, frame_nxt;
  logic [3:0]  byte_cnt_r, byte_cnt_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        clk_out_r, clk_out_nxt;
  logic        dio_out_r, dio_out_nxt;
  logic        float_r, float_nxt;
  logic        ack_r, ack_nxt;
  logic [2:0]  bright_r, bright_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [2:0]  run_bright_r, run_bright_nxt;
  logic [3:0]  run_count_r, run_count_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;

  logic        in_acc;
  logic [1:0]  req;
  logic [2:0]  in_idx;
  logic [7:0]  in_seg;
  logic        in_sample;
  logic        busy;
  logic        rej;
  logic        done;
  logic [3:0]  eff_count;
  logic [3:0]  rd_idx;
  logic [7:0]  rd_byte;

  assign req       = in_tuser;
  assign in_idx    = in_tdata[2:0];
  assign in_seg    = in_tdata[10:3];
  assign in_sample = in_tdata[11];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;
  assign busy       = (phase_r != PH_IDLE);

  // Configuration writes land in shadow registers; a refresh latches them.
  always_comb begin
    bright_nxt = bright_r;
    count_nxt  = count_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS:  bright_nxt = cfg_data[2:0];
        CFG_DIGIT_COUNT: count_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_count = (count_r == 4'd0) ? DEFAULT_COUNT : count_r;
    if ({1'b0, eff_count} > MAX_D) begin
      eff_count = MAX_D[3:0];
    end
  end

  always_comb begin
    rd_idx = byte_cnt_r;
    if (run_count_r == GROUPED_COUNT && byte_cnt_r < 4'd6) begin
      rd_idx = SIX_ORDER[{byte_cnt_r[2:0], 2'b00} +: 4];
    end
    rd_byte = 8'h00;
    if ({1'b0, rd_idx} < MAX_D) begin
      rd_byte = store_r[rd_idx[IDX_W-1:0]];
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    frame_nxt      = frame_r;
    byte_cnt_nxt   = byte_cnt_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    clk_out_nxt    = clk_out_r;
    dio_out_nxt    = dio_out_r;
    float_nxt      = float_r;
    ack_nxt        = ack_r;
    run_bright_nxt = run_bright_r;
    run_count_nxt  = run_count_r;
    store_we       = 1'b0;
    store_wa       = {1'b0, in_idx};
    rej            = 1'b0;
    done           = 1'b0;

    if (in_acc) begin
      case (req)
        REQ_LOAD: begin
          if (busy) begin
            rej = 1'b1;
          end else if ({2'b00, in_idx} < MAX_D) begin
            store_we = 1'b1;
          end
        end
        REQ_REFRESH: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            run_count_nxt  = eff_count;
            run_bright_nxt = bright_r & BRIGHT_MASK;
            frame_nxt      = 2'd0;
            shift_nxt      = CMD_DATA_SET;
            byte_cnt_nxt   = 4'd0;
            bit_cnt_nxt    = 3'd0;
            phase_nxt      = PH_ST0;
          end
        end
        REQ_TICK: begin
          unique case (phase_r)
            PH_IDLE: ;
            PH_ST0: begin
              clk_out_nxt = 1'b1;
              phase_nxt   = PH_ST1;
            end
            PH_ST1: begin
              dio_out_nxt = 1'b1;
              phase_nxt   = PH_ST2;
            end
            PH_ST2: begin
              dio_out_nxt = 1'b0;
              phase_nxt   = PH_ST3;
            end
            PH_ST3: begin
              clk_out_nxt = 1'b0;
              phase_nxt   = PH_BIT0;
            end
            PH_BIT0: begin
              clk_out_nxt = 1'b0;
              phase_nxt   = PH_BIT1;
            end
            PH_BIT1: begin
              dio_out_nxt = shift_r[0];
              shift_nxt   = {1'b0, shift_r[7:1]};
              phase_nxt   = PH_BIT2;
            end
            PH_BIT2: begin
              clk_out_nxt = 1'b1;
              if (bit_cnt_r == LAST_BIT) begin
                bit_cnt_nxt = 3'd0;
                phase_nxt   = PH_ACK0;
              end else begin
                bit_cnt_nxt = bit_cnt_r + 3'd1;
                phase_nxt   = PH_BIT0;
              end
            end
            PH_ACK0: begin
              clk_out_nxt = 1'b0;
              float_nxt   = 1'b1;
              phase_nxt   = PH_ACK1;
            end
            PH_ACK1: begin
              clk_out_nxt = 1'b1;
              ack_nxt     = !in_sample;
              phase_nxt   = PH_ACK2;
            end
            PH_ACK2: begin
              clk_out_nxt = 1'b0;
              float_nxt   = 1'b0;
              if (frame_r == FRAME_DATA && byte_cnt_r < run_count_r) begin
                shift_nxt    = rd_byte;
                byte_cnt_nxt = byte_cnt_r + 4'd1;
                bit_cnt_nxt  = 3'd0;
                phase_nxt    = PH_BIT0;
              end else begin
                phase_nxt = PH_SP0;
              end
            end
            PH_SP0: begin
              clk_out_nxt = 1'b0;
              phase_nxt   = PH_SP1;
            end
            PH_SP1: begin
              dio_out_nxt = 1'b0;
              phase_nxt   = PH_SP2;
            end
            PH_SP2: begin
              clk_out_nxt = 1'b1;
              phase_nxt   = PH_SP3;
            end
            PH_SP3: begin
              dio_out_nxt = 1'b1;
              if (frame_r >= FRAME_DISPLAY) begin
                phase_nxt = PH_IDLE;
                frame_nxt = 2'd0;
                done      = 1'b1;
              end else begin
                // The next frame opens with its command byte.
                frame_nxt    = frame_r + 2'd1;
                shift_nxt    = (frame_r == 2'd0) ? CMD_ADDR_SET
                                                 : (CMD_DISP_CTRL | {5'd0, run_bright_r});
                byte_cnt_nxt = 4'd0;
                bit_cnt_nxt  = 3'd0;
                phase_nxt    = PH_ST0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, done, rej, ack_nxt, (phase_nxt != PH_IDLE),
                       (float_nxt || dio_out_nxt), clk_out_nxt};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      frame_r      <= 2'd0;
      byte_cnt_r   <= 4'd0;
      bit_cnt_r    <= 3'd0;
      shift_r      <= 8'h00;
      clk_out_r    <= 1'b1;
      dio_out_r    <= 1'b1;
      float_r      <= 1'b0;
      ack_r        <= 1'b0;
      bright_r     <= DEFAULT_BRIGHT;
      count_r      <= DEFAULT_COUNT;
      run_bright_r <= DEFAULT_BRIGHT;
      run_count_r  <= DEFAULT_COUNT;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      frame_r      <= frame_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      clk_out_r    <= clk_out_nxt;
      dio_out_r    <= dio_out_nxt;
      float_r      <= float_nxt;
      ack_r        <= ack_nxt;
      bright_r     <= bright_nxt;
      count_r      <= count_nxt;
      run_bright_r <= run_bright_nxt;
      run_count_r  <= run_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        store_r[i] <= 8'h00;
      end
    end else if (store_we) begin
      store_r[store_wa[IDX_W-1:0]] <= in_seg;
    end
  end

  // A busy load or refresh must come back flagged as rejected.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && busy && (req == REQ_LOAD || req == REQ_REFRESH)) |=> out_data_r[4])
    else $error("busy request not rejected");

  // The data line is released only inside the ack window.
  assert property (@(posedge clk) disable iff (!rst_n)
    float_r |-> (phase_r == PH_ACK1 || phase_r == PH_ACK2))
    else $error("data line released outside ack window");

  // An idle sequencer has no bit in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_cnt_r == 3'd0 && frame_r == 2'd0))
    else $error("idle sequencer holds stale counters");

  // A finished refresh reports not busy in the same result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[5]) |-> !out_data_r[2])
    else $error("done reported while busy");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ldsr_pkg::*;

  localparam int STORE_DEPTH = 8;
  localparam int RANDOM_ITEMS = 900;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [7:0] DATA_CMD = 8'h40;
  localparam logic [7:0] ADDR_CMD = 8'hC0;
  localparam logic [7:0] CTRL_CMD = 8'h88;
  localparam logic [3:0] ZERO_COUNT_AS = 4'd4;

  typedef struct packed {
    logic [1:0] req;
    logic [2:0] idx;
    logic [7:0] seg;
    logic       samp;
    logic       typed;
    logic [7:0] want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_index = 1'b0;
  logic [3:0] cfg_data = '0;
  wire        in_tready;
  wire        out_tvalid;
  wire [7:0]  out_tdata;
  wire        cfg_ready;

  led_display_serial_refresh_top #(.MAX_DIGITS(STORE_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mirror of the driver: digit store, pin sequencer and both line levels.
  logic [7:0] seg_mem [STORE_DEPTH];
  phase_t     seq_ph;
  logic [1:0] frame_no;
  logic [3:0] byte_no;
  logic [2:0] bit_no;
  logic [7:0] tx_byte;
  logic       scl_lv, sda_lv, sda_free, ack_low;
  logic [2:0] bright_reg, run_bright;
  logic [3:0] count_reg, run_count;

  logic [7:0] expected_reports [$];
  int errors = 0;
  int sent_count = 0;
  int refreshes_done = 0;
  int rejects_seen = 0;
  int acks_seen = 0;
  int burst_left = 0;
  bit feeding = 0;
  int stall_mode = 0;
  int stall_left = 0;

  function automatic void clear_line_model();
    for (int i = 0; i < STORE_DEPTH; i++) seg_mem[i] = 8'h00;
    seq_ph = PH_IDLE;
    frame_no = 2'd0;
    byte_no = 4'd0;
    bit_no = 3'd0;
    tx_byte = 8'h00;
    scl_lv = 1'b1;
    sda_lv = 1'b1;
    sda_free = 1'b0;
    ack_low = 1'b0;
    bright_reg = 3'd7;
    count_reg = 4'd4;
    run_bright = 3'd7;
    run_count = 4'd4;
  endfunction

  function automatic void load_command();
    if (frame_no == 2'd0) tx_byte = DATA_CMD;
    else if (frame_no == 2'd1) tx_byte = ADDR_CMD;
    else tx_byte = CTRL_CMD | {5'b0, run_bright};
    byte_no = 4'd0;
    bit_no = 3'd0;
  endfunction

  // One pin step; returns 1 when the stop of the display control frame ends.
  function automatic logic pin_step(input logic samp);
    logic [3:0] pos;
    logic [2:0] sel;
    logic       fin;
    fin = 1'b0;
    case (seq_ph)
      PH_ST0: begin scl_lv = 1'b1; seq_ph = PH_ST1; end
      PH_ST1: begin sda_lv = 1'b1; seq_ph = PH_ST2; end
      PH_ST2: begin sda_lv = 1'b0; seq_ph = PH_ST3; end
      PH_ST3: begin scl_lv = 1'b0; seq_ph = PH_BIT0; end
      PH_BIT0: begin scl_lv = 1'b0; seq_ph = PH_BIT1; end
      PH_BIT1: begin
        sda_lv = tx_byte[0];
        tx_byte = tx_byte >> 1;
        seq_ph = PH_BIT2;
      end
      PH_BIT2: begin
        scl_lv = 1'b1;
        if (bit_no == 3'd7) begin
          bit_no = 3'd0;
          seq_ph = PH_ACK0;
        end else begin
          bit_no = bit_no + 3'd1;
          seq_ph = PH_BIT0;
        end
      end
      PH_ACK0: begin scl_lv = 1'b0; sda_free = 1'b1; seq_ph = PH_ACK1; end
      PH_ACK1: begin scl_lv = 1'b1; ack_low = ~samp; seq_ph = PH_ACK2; end
      PH_ACK2: begin
        scl_lv = 1'b0;
        sda_free = 1'b0;
        if (frame_no == 2'd1 && byte_no < run_count) begin
          pos = byte_no;
          // With six digits the two groups of three go out reversed.
          if (run_count == 4'd6 && pos < 4'd6)
            sel = (pos < 4'd3) ? 3'(4'd2 - pos) : 3'(4'd8 - pos);
          else
            sel = pos[2:0];
          tx_byte = seg_mem[sel];
          byte_no = byte_no + 4'd1;
          bit_no = 3'd0;
          seq_ph = PH_BIT0;
        end else begin
          seq_ph = PH_SP0;
        end
      end
      PH_SP0: begin scl_lv = 1'b0; seq_ph = PH_SP1; end
      PH_SP1: begin sda_lv = 1'b0; seq_ph = PH_SP2; end
      PH_SP2: begin scl_lv = 1'b1; seq_ph = PH_SP3; end
      PH_SP3: begin
        sda_lv = 1'b1;
        if (frame_no == 2'd2) begin
          seq_ph = PH_IDLE;
          frame_no = 2'd0;
          fin = 1'b1;
        end else begin
          frame_no = frame_no + 2'd1;
          load_command();
          seq_ph = PH_ST0;
        end
      end
      default: ;
    endcase
    return fin;
  endfunction

  function automatic logic [7:0] predict_report(input logic [1:0] req, input logic [2:0] idx,
                                                input logic [7:0] seg, input logic samp);
    logic busy, rej, fin;
    busy = (seq_ph != PH_IDLE);
    rej = 1'b0;
    fin = 1'b0;
    case (req)
      REQ_LOAD: begin
        if (busy) rej = 1'b1;
        else seg_mem[idx] = seg;
      end
      REQ_REFRESH: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          if (count_reg == 4'd0) run_count = ZERO_COUNT_AS;
          else if (count_reg > STORE_DEPTH) run_count = 4'(STORE_DEPTH);
          else run_count = count_reg;
          run_bright = bright_reg;
          frame_no = 2'd0;
          load_command();
          seq_ph = PH_ST0;
        end
      end
      REQ_TICK: fin = pin_step(samp);
      default: ;
    endcase
    return {2'b00, fin, rej, ack_low, seq_ph != PH_IDLE, sda_free | sda_lv, scl_lv};
  endfunction

  // Sends one request in bursts with random gaps; records the expected report.
  task automatic send_request(input logic [1:0] req, input logic [2:0] idx,
                              input logic [7:0] seg, input logic samp,
                              input logic typed = 1'b0, input logic [7:0] want = 8'h00);
    int gap;
    logic [7:0] predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = $urandom_range(1, 5);
      if (feeding) in_tvalid <= 1'b0;
      feeding = 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {4'b0000, samp, seg, idx};
    feeding = 1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_count++;
    predicted = predict_report(req, idx, seg, samp);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  task automatic idle_input();
    if (feeding) begin
      in_tvalid <= 1'b0;
      feeding = 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Writes both registers; the spare top bit of the brightness write is random.
  task automatic write_regs(input logic [2:0] br, input logic [3:0] cnt);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BRIGHTNESS;
    cfg_data <= {1'($urandom_range(0, 1)), br};
    do @(posedge clk); while (!cfg_ready);
    bright_reg = br;
    cfg_index <= CFG_DIGIT_COUNT;
    cfg_data <= cnt;
    do @(posedge clk); while (!cfg_ready);
    count_reg = cnt;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ticks a running refresh to its end, mixed with stray requests and at most
  // one register write in the middle, which must only affect the next refresh.
  task automatic tick_until_idle();
    int mid_at, ticks, r;
    mid_at = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 150) : -1;
    ticks = 0;
    while (seq_ph != PH_IDLE) begin
      if (ticks == mid_at) begin
        idle_input();
        drain();
        write_regs(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      end
      r = $urandom_range(0, 99);
      if (r < 4)
        send_request(REQ_LOAD, 3'($urandom), 8'($urandom), 1'($urandom));
      else if (r < 7)
        send_request(REQ_REFRESH, 3'($urandom), 8'($urandom), 1'($urandom));
      else if (r < 9)
        send_request(REQ_UNUSED, 3'($urandom), 8'($urandom), 1'($urandom));
      else
        send_request(REQ_TICK, 3'($urandom), 8'($urandom), $urandom_range(0, 9) < 3);
      ticks++;
    end
  endtask

  task automatic refresh_phase(input logic [2:0] br, input logic [3:0] cnt);
    idle_input();
    drain();
    write_regs(br, cnt);
    repeat ($urandom_range(0, 8))
      send_request(REQ_LOAD, 3'($urandom), 8'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 2))
      send_request($urandom_range(0, 1) ? REQ_TICK : REQ_UNUSED, 3'($urandom),
                   8'($urandom), 1'($urandom));
    send_request(REQ_REFRESH, 3'($urandom), 8'($urandom), 1'($urandom));
    tick_until_idle();
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    logic [7:0] want;
    string fname;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t ns: report with none expected: expected nothing, actual %h",
                 $time, out_tdata);
      end else begin
        want = expected_reports.pop_front();
        for (int b = 0; b < 8; b++) begin
          if (out_tdata[b] !== want[b]) begin
            case (b)
              0: fname = "clk_level";
              1: fname = "dio_release";
              2: fname = "busy_res";
              3: fname = "ack_ok";
              4: fname = "rejected";
              5: fname = "done_res";
              default: fname = "pad";
            endcase
            errors++;
            $display("%0t ns: %s mismatch: expected %b, actual %b (report %h vs %h)",
                     $time, fname, want[b], out_tdata[b], want, out_tdata);
          end
        end
        if (want[5]) refreshes_done++;
        if (want[4]) rejects_seen++;
        if (want[3]) acks_seen++;
      end
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    logic [2:0] br;
    logic [3:0] cnt;
    int k;

    // Idle behavior and loads at the field extremes, then a refresh with the
    // reset register values; loads and refreshes made while it runs are turned away.
    dir_rows.push_back({REQ_TICK,    3'd0, 8'h00, 1'b1, 1'b1, 8'h03});
    dir_rows.push_back({REQ_TICK,    3'd7, 8'hFF, 1'b0, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd0, 8'h00, 1'b0, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd7, 8'hFF, 1'b1, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd5, 8'h80, 1'b0, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd1, 8'h01, 1'b0, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd2, 8'h7F, 1'b1, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd3, 8'hA5, 1'b0, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd4, 8'h5A, 1'b1, 1'b1, 8'h03});
    dir_rows.push_back({REQ_LOAD,    3'd6, 8'hC3, 1'b0, 1'b1, 8'h03});
    dir_rows.push_back({REQ_UNUSED,  3'd7, 8'hFF, 1'b1, 1'b1, 8'h03});
    dir_rows.push_back({REQ_REFRESH, 3'd0, 8'h00, 1'b0, 1'b1, 8'h07});
    dir_rows.push_back({REQ_LOAD,    3'd2, 8'h55, 1'b0, 1'b1, 8'h17});
    dir_rows.push_back({REQ_REFRESH, 3'd7, 8'hFF, 1'b1, 1'b1, 8'h17});
    dir_rows.push_back({REQ_UNUSED,  3'd0, 8'h00, 1'b0, 1'b1, 8'h07});
    dir_rows.push_back({REQ_TICK,    3'd0, 8'h00, 1'b0, 1'b1, 8'h07});
    dir_rows.push_back({REQ_TICK,    3'd0, 8'h00, 1'b1, 1'b1, 8'h07});
    dir_rows.push_back({REQ_TICK,    3'd0, 8'h00, 1'b0, 1'b1, 8'h05});
    dir_rows.push_back({REQ_TICK,    3'd0, 8'h00, 1'b1, 1'b1, 8'h04});
    dir_rows.push_back({REQ_TICK,    3'd3, 8'h12, 1'b0, 1'b0, 8'h00});
    dir_rows.push_back({REQ_TICK,    3'd4, 8'h34, 1'b1, 1'b0, 8'h00});
    dir_rows.push_back({REQ_TICK,    3'd5, 8'h56, 1'b0, 1'b0, 8'h00});
    dir_rows.push_back({REQ_LOAD,    3'd1, 8'hEE, 1'b1, 1'b0, 8'h00});
    dir_rows.push_back({REQ_TICK,    3'd6, 8'h78, 1'b1, 1'b0, 8'h00});

    clear_line_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].seg, dir_rows[i].samp,
                   dir_rows[i].typed, dir_rows[i].want);

    tick_until_idle();

    // Register extremes first (zero and oversized counts, grouped order),
    // then random settings, mostly short counts, until enough requests went out.
    k = 0;
    do begin
      case (k)
        0: begin br = 3'd0; cnt = 4'd1; end
        1: begin br = 3'd7; cnt = 4'd15; end
        2: begin br = 3'd3; cnt = 4'd6; end
        3: begin br = 3'd5; cnt = 4'd0; end
        default: begin
          br = 3'($urandom_range(0, 7));
          cnt = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
        end
      endcase
      refresh_phase(br, cnt);
      k++;
    end while (k < 4 || sent_count < RANDOM_ITEMS);

    idle_input();
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests over %0d register settings plus the reset defaults.",
             sent_count, k);
    $display("Saw %0d finished refreshes, %0d turned-away requests, %0d ack-ok reports.",
             refreshes_done, rejects_seen, acks_seen);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> led_display_serial_refresh_top.f
rtl/core/ldsr_pkg.sv
rtl/core/led_display_serial_refresh_top.sv
test/tb_top.sv
